FILE: hw/rtl/pbr_pkg.sv
// Package for the paged boot ROM and line clock register block.
// Holds word types, operation codes, bus addresses and ROM/clock constants.
// No dependencies.
package pbr_pkg;

    localparam int ROM_PAGES  = 16;
    localparam int PAGE_WORDS = 128;
    localparam int TICK_MS    = 20;

    localparam int ROM_DEPTH = ROM_PAGES * PAGE_WORDS;
    localparam int ROM_AW    = (ROM_DEPTH > 1) ? $clog2(ROM_DEPTH) : 1;
    localparam int ACC_W     = 5;
    localparam int SUM_W     = 9;

    // floor(2^16 / TICK_MS): quotient estimate is low by at most one
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = 17;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / TICK_MS);

    localparam logic [2:0] OP_READ  = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_TICK  = 3'd2;
    localparam logic [2:0] OP_RESET = 3'd3;
    localparam logic [2:0] OP_LOAD  = 3'd4;

    localparam logic [15:0] A_PCR     = 16'o177520;
    localparam logic [15:0] A_SCRATCH = 16'o177522;
    localparam logic [15:0] A_SWITCH  = 16'o177524;
    localparam logic [15:0] A_LTC     = 16'o177546;
    localparam logic [15:0] A_WIN_LO  = 16'o173000;
    localparam logic [15:0] A_WIN_HI  = 16'o173400;
    localparam logic [15:0] A_WIN_END = 16'o173776;

    localparam logic [15:0] NO_PAGE_LO = 16'o177777;
    localparam logic [15:0] NO_PAGE_HI = 16'o000233;
    localparam int          LTC_BIT    = 6;
    localparam logic [15:0] SWITCH_RST = 16'd105;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [7:0]  elapsed_ms;
        logic        cpu_accepts;
    } t_in_word;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_request;
        logic        period_elapsed;
    } t_out_word;

endpackage

FILE: hw/rtl/paged_boot_rom_and_line_clock_regs.sv
// Top level: bus registers, paged boot ROM memory and line clock.
// Depends on pbr_pkg.
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+---------------------------
//  in       | i_in_valid / o_in_ready / i_in   | one bus, tick, reset or load word
//  out      | o_out_valid / i_out_ready / o_out| one result word per input word
//  cfg      | i_cfg_we / i_cfg_wdata           | switch setting, no wait
//
// One word per cycle sustained while the output is not stalled; each result
// passes through the ROM read stage (synchronous ROM read), then the output
// register. A stalled output still lets one more word in (held in the
// ROM read stage). Reset is synchronous; the ROM has no reset and no clearing.
module paged_boot_rom_and_line_clock_regs
    import pbr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out,
    input  logic      i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0]      r_switch;
    logic [15:0]      r_page_ctl, n_page_ctl;
    logic [15:0]      r_scratch, n_scratch;
    logic             r_clk_en, n_clk_en;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic             r_pend, n_pend;

    logic [15:0]      r_rom [ROM_DEPTH];
    logic [15:0]      r_rom_q;

    logic             r_s1_valid;
    logic             r_s1_rom;
    t_out_word        r_s1_res, n_s1_res;
    t_out_word        s1_fwd;
    logic             r_out_valid;
    t_out_word        r_out;

    logic             in_acc, s1_adv;
    logic             use_rom;
    logic [ROM_AW-1:0] rd_idx;
    logic [14:0]      win_idx;
    logic [7:0]       page;
    logic             win_lo, win_hi;
    logic             rom_we;

    logic [SUM_W-1:0]         sum;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [SUM_W-1:0]         quo;
    logic [SUM_W+4:0]         qd;
    logic [SUM_W-1:0]         rem0, rem;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    // ROM window decode; low address bit is dropped inside a window
    assign win_lo  = i_in.address >= A_WIN_LO && i_in.address < A_WIN_HI;
    assign win_hi  = i_in.address >= A_WIN_HI && i_in.address < A_WIN_END;
    assign page    = win_lo ? r_page_ctl[7:0] : r_page_ctl[15:8];
    assign win_idx = {page, i_in.address[7:1]};
    assign rd_idx  = win_idx[ROM_AW-1:0];
    assign rom_we  = in_acc && i_in.op == OP_LOAD
                     && {1'b0, i_in.address} < 17'(ROM_DEPTH);

    // tick: remainder by reciprocal multiply, one correcting subtract
    assign sum  = SUM_W'(r_acc) + SUM_W'(i_in.elapsed_ms);
    assign prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP);
    assign quo  = prod[RECIP_SH +: SUM_W];
    assign qd   = (SUM_W+5)'(quo) * (SUM_W+5)'(TICK_MS);
    assign rem0 = sum - qd[SUM_W-1:0];
    assign rem  = (rem0 >= SUM_W'(TICK_MS)) ? rem0 - SUM_W'(TICK_MS) : rem0;

    always_comb begin
        n_page_ctl = r_page_ctl;
        n_scratch  = r_scratch;
        n_clk_en   = r_clk_en;
        n_acc      = r_acc;
        n_pend     = r_pend;
        n_s1_res   = '0;
        use_rom    = 1'b0;
        case (i_in.op)
            OP_READ: begin
                case (i_in.address)
                    A_PCR:     n_s1_res.read_data = r_page_ctl;
                    A_SCRATCH: n_s1_res.read_data = r_scratch;
                    A_SWITCH:  n_s1_res.read_data = r_switch;
                    A_LTC:     n_s1_res.read_data = 16'(r_clk_en) << LTC_BIT;
                    default: begin
                        if (win_lo || win_hi) begin
                            if ({1'b0, page} >= 9'(ROM_PAGES)) begin
                                n_s1_res.read_data = win_lo ? NO_PAGE_LO : NO_PAGE_HI;
                            end else begin
                                use_rom = 1'b1;
                            end
                        end
                    end
                endcase
            end
            OP_WRITE: begin
                case (i_in.address)
                    A_PCR:     n_page_ctl = i_in.write_data;
                    A_SCRATCH: n_scratch  = i_in.write_data;
                    A_LTC:     n_clk_en   = i_in.write_data[LTC_BIT];
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (sum >= SUM_W'(TICK_MS)) begin
                    n_acc  = rem[ACC_W-1:0];
                    n_pend = 1'b1;
                    n_s1_res.period_elapsed = 1'b1;
                end else begin
                    n_acc = sum[ACC_W-1:0];
                end
                if (r_clk_en && n_pend) begin
                    n_s1_res.irq_request = 1'b1;
                    if (i_in.cpu_accepts) begin
                        n_pend = 1'b0;
                    end
                end
            end
            OP_RESET: begin
                n_page_ctl = '0;
                n_scratch  = '0;
                n_pend     = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rom_we) begin
            r_rom[i_in.address[ROM_AW-1:0]] <= i_in.write_data;
        end
        if (in_acc && use_rom) begin
            r_rom_q <= r_rom[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch    <= SWITCH_RST;
            r_page_ctl  <= '0;
            r_scratch   <= '0;
            r_clk_en    <= 1'b0;
            r_acc       <= '0;
            r_pend      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_switch <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_page_ctl <= n_page_ctl;
                r_scratch  <= n_scratch;
                r_clk_en   <= n_clk_en;
                r_acc      <= n_acc;
                r_pend     <= n_pend;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ROM data replaces the read field for window reads
    always_comb begin
        s1_fwd = r_s1_res;
        if (r_s1_rom) begin
            s1_fwd.read_data = r_rom_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_res <= n_s1_res;
            r_s1_rom <= use_rom;
        end
        if (s1_adv) begin
            r_out <= s1_fwd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hw/rtl/pbr_checker.sv
// Port-level checker for the paged boot ROM block, with its bind.
// Depends on pbr_pkg and the top level's ports.
module pbr_port_checks
    import pbr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out
);

    // words taken in but not yet delivered
    logic [1:0] r_cnt;
    logic       in_acc, out_acc;

    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 2'd0)
        else $error("result without an outstanding word");

    // two in flight: input only opens when the output drains this cycle
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3 && (r_cnt != 2'd2 || i_out_ready || !o_in_ready))
        else $error("more than two words in flight");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled while output is free");

endmodule

bind paged_boot_rom_and_line_clock_regs pbr_port_checks u_pbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
